/* sv/vrsd_pkg.sv */
// Shared constants, command codes and controller/datapath handshake types.
`default_nettype none

package vrsd_pkg;

   localparam int GRAPHICS_WORDS = 7168;
   localparam int SPRITE_START   = 6144;
   localparam int REGISTER_COUNT = 32;
   localparam int SPRITE_WORDS   = 1024;

   localparam int GRAM_IDX_W   = $clog2(GRAPHICS_WORDS);
   localparam int REG_IDX_W    = $clog2(REGISTER_COUNT);
   localparam int SPRITE_IDX_W = $clog2(SPRITE_WORDS);
   localparam int COPY_CNT_W   = SPRITE_IDX_W + 1;

   localparam logic [REG_IDX_W-1:0] FLIP_REG = REG_IDX_W'(15);
   localparam int FLIP_BIT = 7;

   typedef enum logic [2:0] {
      CMD_SET_GADDR  = 3'd0,
      CMD_READ_GRAM  = 3'd1,
      CMD_WRITE_GRAM = 3'd2,
      CMD_SET_RADDR  = 3'd3,
      CMD_WRITE_VREG = 3'd4,
      CMD_FRAME_END  = 3'd5,
      CMD_READ_SPR   = 3'd6,
      CMD_NOP        = 3'd7
   } cmd_type;

   typedef struct packed {
      logic accept;
      logic copy_active;
   } ctrl_type;

   typedef struct packed {
      logic frame_end_cmd;
      logic s1_free;
      logic copy_done;
   } stat_type;

endpackage

`default_nettype wire

/* sv/vrsd_if.sv */
// Request and response channel interfaces.
`default_nettype none

interface vrsd_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [15:0] data;
   logic [9:0]  sprite_index;

   modport source (output valid, output cmd, output data, output sprite_index, input ready);
   modport sink   (input valid, input cmd, input data, input sprite_index, output ready);
endinterface

interface vrsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_data;
   logic        out_of_bounds;
   logic        dirty_valid;
   logic [1:0]  dirty_layer;
   logic [9:0]  dirty_tile;
   logic        screen_flip;

   modport source (output valid, output read_data, output out_of_bounds, output dirty_valid,
                   output dirty_layer, output dirty_tile, output screen_flip, input ready);
   modport sink   (input valid, input read_data, input out_of_bounds, input dirty_valid,
                   input dirty_layer, input dirty_tile, input screen_flip, output ready);
endinterface

`default_nettype wire

/* sv/vrsd_datapath.sv */
// Address counters, graphics RAM, register file, sprite buffers and result stages.
`default_nettype none

module vrsd_datapath
   import vrsd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctrl_type    ctrl,
   output      stat_type    stat,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [15:0] req_data,
   input  wire logic [9:0]  req_sprite_index,
   vrsd_rsp_if.source       rsp_chan
);

   typedef enum logic [1:0] {
      SRC_NONE   = 2'd0,
      SRC_GRAM   = 2'd1,
      SRC_SPRITE = 2'd2
   } src_type;

   localparam logic [15:0] GRAM_LIMIT   = 16'(GRAPHICS_WORDS);
   localparam logic [15:0] SPRITE_LIMIT = 16'(SPRITE_START);
   localparam logic [7:0]  REG_LIMIT    = 8'(REGISTER_COUNT);

   logic [15:0] gram [GRAPHICS_WORDS];
   logic [15:0] spr_shown [SPRITE_WORDS];
   logic [15:0] spr_pending [SPRITE_WORDS];

   logic [15:0] gaddr_ff, gaddr_in;
   logic [6:0]  raddr_ff, raddr_in;
   logic [15:0] vreg_ff [REGISTER_COUNT];
   logic        primed_ff;

   logic        s1_valid_ff, s1_valid_in;
   src_type     s1_src_ff, s1_src_in;
   logic        s1_oob_ff, s1_oob_in;
   logic        s1_dv_ff, s1_dv_in;
   logic [1:0]  s1_dl_ff, s1_dl_in;
   logic [9:0]  s1_dt_ff, s1_dt_in;
   logic        s1_primed_ff;

   logic        rsp_valid_ff;
   logic [15:0] rsp_rd_ff;
   logic        rsp_oob_ff, rsp_dv_ff, rsp_flip_ff;
   logic [1:0]  rsp_dl_ff;
   logic [9:0]  rsp_dt_ff;

   logic [15:0] gram_q_ff;
   logic [15:0] shown_q_ff;
   logic [15:0] pend_q_ff;

   logic [COPY_CNT_W-1:0]   cnt_ff;
   logic                    wr_valid_ff;
   logic [SPRITE_IDX_W-1:0] wr_idx_ff;
   logic                    wr_inrange_ff;

   logic                  in_gram, below_sprite, in_regs, out_free;
   logic                  gram_we, gram_re, vreg_we, shown_re;
   logic [GRAM_IDX_W-1:0] acc_idx, copy_idx, rd_idx;
   logic [16:0]           copy_addr;
   logic                  copy_issue, copy_inrange;
   logic [REG_IDX_W-1:0]  vreg_idx;
   logic [15:0]           rd_sel;

   assign in_gram      = gaddr_ff < GRAM_LIMIT;
   assign below_sprite = gaddr_ff < SPRITE_LIMIT;
   assign in_regs      = {1'b0, raddr_ff} < REG_LIMIT;
   assign acc_idx      = gaddr_ff[GRAM_IDX_W-1:0];
   assign vreg_idx     = raddr_ff[REG_IDX_W-1:0];
   assign out_free     = !rsp_valid_ff || rsp_chan.ready;

   assign copy_addr    = 17'(SPRITE_START) + 17'(cnt_ff);
   assign copy_inrange = copy_addr < 17'(GRAPHICS_WORDS);
   assign copy_idx     = copy_addr[GRAM_IDX_W-1:0];
   assign copy_issue   = ctrl.copy_active && !cnt_ff[COPY_CNT_W-1];

   assign stat.frame_end_cmd = req_cmd == CMD_FRAME_END;
   assign stat.s1_free       = !s1_valid_ff || out_free;
   assign stat.copy_done     = ctrl.copy_active && (cnt_ff == COPY_CNT_W'(SPRITE_WORDS));

   always_comb begin
      gaddr_in  = gaddr_ff;
      raddr_in  = raddr_ff;
      gram_we   = 1'b0;
      gram_re   = 1'b0;
      vreg_we   = 1'b0;
      shown_re  = 1'b0;
      s1_src_in = SRC_NONE;
      s1_oob_in = 1'b0;
      s1_dv_in  = 1'b0;
      s1_dl_in  = 2'd0;
      s1_dt_in  = 10'd0;
      if (ctrl.accept) begin
         unique case (req_cmd)
            CMD_SET_GADDR: gaddr_in = req_data;
            CMD_READ_GRAM: begin
               if (in_gram) begin
                  gram_re   = 1'b1;
                  s1_src_in = SRC_GRAM;
                  gaddr_in  = gaddr_ff + 16'd1;
               end else begin
                  s1_oob_in = 1'b1;
               end
            end
            CMD_WRITE_GRAM: begin
               if (in_gram) begin
                  gram_we  = 1'b1;
                  gaddr_in = gaddr_ff + 16'd1;
                  if (below_sprite) begin
                     s1_dv_in = 1'b1;
                     s1_dl_in = gaddr_ff[12:11];
                     s1_dt_in = gaddr_ff[10:1];
                  end
               end else begin
                  s1_oob_in = 1'b1;
               end
            end
            CMD_SET_RADDR: raddr_in = req_data[6:0];
            CMD_WRITE_VREG: begin
               if (in_regs) begin
                  vreg_we  = 1'b1;
                  raddr_in = raddr_ff + 7'd1;
               end else begin
                  s1_oob_in = 1'b1;
               end
            end
            CMD_READ_SPR: begin
               shown_re  = 1'b1;
               s1_src_in = SRC_SPRITE;
            end
            default: ;
         endcase
      end
   end

   assign s1_valid_in = ctrl.accept || (s1_valid_ff && !out_free);

   // one read port: the copy sweep owns it while s1 holds only the frame-end item
   assign rd_idx = ctrl.copy_active ? copy_idx : acc_idx;

   always_ff @(posedge clock) begin
      if (gram_we) begin
         gram[acc_idx] <= req_data;
      end
      if (gram_re || (copy_issue && copy_inrange)) begin
         gram_q_ff <= gram[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (shown_re) begin
         shown_q_ff <= spr_shown[req_sprite_index[SPRITE_IDX_W-1:0]];
      end
      if (wr_valid_ff) begin
         spr_shown[wr_idx_ff] <= primed_ff ? pend_q_ff : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (copy_issue) begin
         pend_q_ff <= spr_pending[cnt_ff[SPRITE_IDX_W-1:0]];
      end
      if (wr_valid_ff) begin
         spr_pending[wr_idx_ff] <= wr_inrange_ff ? gram_q_ff : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gaddr_ff     <= 16'd0;
         raddr_ff     <= 7'd0;
         primed_ff    <= 1'b0;
         cnt_ff       <= '0;
         wr_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < REGISTER_COUNT; i++) begin
            vreg_ff[i] <= 16'd0;
         end
      end else begin
         gaddr_ff    <= gaddr_in;
         raddr_ff    <= raddr_in;
         s1_valid_ff <= s1_valid_in;
         wr_valid_ff <= copy_issue;
         if (vreg_we) begin
            vreg_ff[vreg_idx] <= req_data;
         end
         if (ctrl.copy_active) begin
            cnt_ff <= cnt_ff + COPY_CNT_W'(1);
         end else begin
            cnt_ff <= '0;
         end
         // both buffers hold defined words once the first sweep is done
         if (stat.copy_done) begin
            primed_ff <= 1'b1;
         end
         if (s1_valid_ff && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      wr_idx_ff     <= cnt_ff[SPRITE_IDX_W-1:0];
      wr_inrange_ff <= copy_inrange;
      if (ctrl.accept) begin
         s1_src_ff    <= s1_src_in;
         s1_oob_ff    <= s1_oob_in;
         s1_dv_ff     <= s1_dv_in;
         s1_dl_ff     <= s1_dl_in;
         s1_dt_ff     <= s1_dt_in;
         s1_primed_ff <= primed_ff;
      end
   end

   always_comb begin
      unique case (s1_src_ff)
         SRC_GRAM:   rd_sel = gram_q_ff;
         SRC_SPRITE: rd_sel = s1_primed_ff ? shown_q_ff : 16'd0;
         default:    rd_sel = 16'd0;
      endcase
   end

   // flip comes from the register file as left by the item leaving s1
   always_ff @(posedge clock) begin
      if (s1_valid_ff && out_free) begin
         rsp_rd_ff   <= rd_sel;
         rsp_oob_ff  <= s1_oob_ff;
         rsp_dv_ff   <= s1_dv_ff;
         rsp_dl_ff   <= s1_dl_ff;
         rsp_dt_ff   <= s1_dt_ff;
         rsp_flip_ff <= vreg_ff[FLIP_REG][FLIP_BIT];
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.read_data     = rsp_rd_ff;
   assign rsp_chan.out_of_bounds = rsp_oob_ff;
   assign rsp_chan.dirty_valid   = rsp_dv_ff;
   assign rsp_chan.dirty_layer   = rsp_dl_ff;
   assign rsp_chan.dirty_tile    = rsp_dt_ff;
   assign rsp_chan.screen_flip   = rsp_flip_ff;

endmodule

`default_nettype wire

/* sv/vrsd_controller.sv */
// Controller: accepts items and runs the frame-end sprite buffer sweep.
`default_nettype none

module vrsd_controller
   import vrsd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output      logic     req_ready,
   input  wire stat_type stat,
   output      ctrl_type ctrl
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_COPY = 2'b10
   } state_type;

   state_type state_ff, state_in;

   assign req_ready        = (state_ff == ST_IDLE) && stat.s1_free;
   assign ctrl.accept      = req_valid && req_ready;
   assign ctrl.copy_active = state_ff == ST_COPY;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (ctrl.accept && stat.frame_end_cmd) state_in = ST_COPY;
         ST_COPY: if (stat.copy_done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_accept_in_copy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY |-> !ctrl.accept)
      else $error("item accepted during sprite sweep");

   a_frame_end_starts_copy: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept && stat.frame_end_cmd |=> state_ff == ST_COPY)
      else $error("frame end did not start sprite sweep");

   a_copy_done_ends: assert property (@(posedge clock) disable iff (reset)
      stat.copy_done |=> state_ff == ST_IDLE && !stat.copy_done)
      else $error("sprite sweep did not finish cleanly");

   a_done_only_in_copy: assert property (@(posedge clock) disable iff (reset)
      stat.copy_done |-> state_ff == ST_COPY)
      else $error("sweep done outside copy state");

endmodule

`default_nettype wire

/* sv/video_ram_port_with_sprite_delay.sv */
// Two register stages: an accepted item enters s1, then the output register, which offers its result.
// Throughput: one item per cycle while results are taken and no sprite sweep runs;
// the output register and the s1 stage hold items while the result side stalls.
// Frame end: input is held while the sprite sweep runs over the RAM port.
// Reset: synchronous; sprite buffers read zero until the first sweep, no clearing pass.
`default_nettype none

module video_ram_port_with_sprite_delay
   import vrsd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   vrsd_req_if.sink   req_chan,
   vrsd_rsp_if.source rsp_chan
);

   ctrl_type ctrl;
   stat_type stat;
   logic     req_ready;

   assign req_chan.ready = req_ready;

   vrsd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   vrsd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_cmd          (req_chan.cmd),
      .req_data         (req_chan.data),
      .req_sprite_index (req_chan.sprite_index),
      .rsp_chan         (rsp_chan)
   );

endmodule

`default_nettype wire

/* tb/video_ram_port_with_sprite_delay_test.sv */
// Self-checking test of the video RAM port with its two-frame sprite delay.
`default_nettype none

module video_ram_port_with_sprite_delay_test
   import vrsd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 8000;
   localparam int REPORT_LINES = 40;

   typedef struct packed {
      logic [15:0] read_data;
      logic        out_of_bounds;
      logic        dirty_valid;
      logic [1:0]  dirty_layer;
      logic [9:0]  dirty_tile;
      logic        screen_flip;
   } vram_response_type;

   logic clock = 1'b0;
   logic reset;

   vrsd_req_if req_chan ();
   vrsd_rsp_if rsp_chan ();

   video_ram_port_with_sprite_delay u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   // Shadow state of the block
   logic [15:0] gram_words [GRAPHICS_WORDS];
   bit          gram_written [GRAPHICS_WORDS];
   logic [15:0] gram_addr;
   logic [6:0]  vreg_addr;
   logic [15:0] vregs [REGISTER_COUNT];
   logic [15:0] sprite_shown [SPRITE_WORDS];
   logic [15:0] sprite_pending [SPRITE_WORDS];
   bit          shown_known [SPRITE_WORDS];
   bit          pending_known [SPRITE_WORDS];

   vram_response_type pending_responses [$];
   int unsigned       write_starts [$];

   int error_count = 0;
   int result_count = 0;
   int items_sent = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_cycles = 0;

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      error_count++;
      if (error_count <= REPORT_LINES)
         $display("%0t result %0d: %s got 0x%0h, expected 0x%0h",
                  $realtime, result_count, field, got, want);
   endtask

   // Advance the shadow state by one item and queue the response it must produce.
   task automatic compute_vram_response(input cmd_type c, input logic [15:0] d,
                                        input logic [9:0] idx);
      vram_response_type r;
      int unsigned a;
      int unsigned sa;
      int i;
      r = '0;
      a = gram_addr;
      case (c)
         CMD_SET_GADDR: gram_addr = d;
         CMD_READ_GRAM: begin
            if (a < GRAPHICS_WORDS) begin
               r.read_data = gram_words[a];
               gram_addr = gram_addr + 16'd1;
            end else begin
               r.out_of_bounds = 1'b1;
            end
         end
         CMD_WRITE_GRAM: begin
            if (a < GRAPHICS_WORDS) begin
               if (a < SPRITE_START) begin
                  r.dirty_valid = 1'b1;
                  r.dirty_layer = 2'(a / 32'h800);
                  r.dirty_tile = 10'((a & 32'h7ff) >> 1);
               end
               gram_words[a] = d;
               gram_written[a] = 1'b1;
               gram_addr = gram_addr + 16'd1;
            end else begin
               r.out_of_bounds = 1'b1;
            end
         end
         CMD_SET_RADDR: vreg_addr = d[6:0];
         CMD_WRITE_VREG: begin
            if (vreg_addr < REGISTER_COUNT) begin
               vregs[vreg_addr] = d;
               vreg_addr = vreg_addr + 7'd1;
            end else begin
               r.out_of_bounds = 1'b1;
            end
         end
         CMD_FRAME_END: begin
            for (i = 0; i < SPRITE_WORDS; i++) begin
               sprite_shown[i] = sprite_pending[i];
               shown_known[i] = pending_known[i];
               sa = SPRITE_START + i;
               if (sa < GRAPHICS_WORDS) begin
                  sprite_pending[i] = gram_words[sa];
                  pending_known[i] = gram_written[sa];
               end else begin
                  sprite_pending[i] = 16'h0;
                  pending_known[i] = 1'b1;
               end
            end
         end
         CMD_READ_SPR: r.read_data = sprite_shown[idx];
         default: ;
      endcase
      r.screen_flip = vregs[FLIP_REG][FLIP_BIT];
      pending_responses.push_back(r);
   endtask

   // Offer one item, hold it until taken, then predict its response.
   task automatic send_item(input cmd_type c, input logic [15:0] d, input logic [9:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd <= c;
      req_chan.data <= d;
      req_chan.sprite_index <= idx;
      @(negedge clock);
      while (!req_chan.ready) @(negedge clock);
      @(posedge clock);
      compute_vram_response(c, d, idx);
      if (c != CMD_NOP) items_sent++;
   endtask

   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic check_response();
      vram_response_type want;
      if (pending_responses.size() == 0) begin
         report_mismatch("response with no item pending", rsp_chan.read_data, 16'h0);
         return;
      end
      want = pending_responses.pop_front();
      result_count++;
      if (rsp_chan.read_data !== want.read_data)
         report_mismatch("read_data", rsp_chan.read_data, want.read_data);
      if (rsp_chan.out_of_bounds !== want.out_of_bounds)
         report_mismatch("out_of_bounds", 16'(rsp_chan.out_of_bounds), 16'(want.out_of_bounds));
      if (rsp_chan.dirty_valid !== want.dirty_valid)
         report_mismatch("dirty_valid", 16'(rsp_chan.dirty_valid), 16'(want.dirty_valid));
      if (rsp_chan.dirty_layer !== want.dirty_layer)
         report_mismatch("dirty_layer", 16'(rsp_chan.dirty_layer), 16'(want.dirty_layer));
      if (rsp_chan.dirty_tile !== want.dirty_tile)
         report_mismatch("dirty_tile", 16'(rsp_chan.dirty_tile), 16'(want.dirty_tile));
      if (rsp_chan.screen_flip !== want.screen_flip)
         report_mismatch("screen_flip", 16'(rsp_chan.screen_flip), 16'(want.screen_flip));
   endtask

   // Sample at the falling edge: a handshake seen here completes at the next rising edge.
   always @(negedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) check_response();
   end

   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(negedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Mixed traffic: mostly address-then-burst sequences with random content, some noise.
   task automatic run_traffic(input int n_items);
      int unsigned target;
      int unsigned pick;
      int unsigned len;
      int unsigned k;
      int unsigned j;
      int unsigned start;
      logic [15:0] word;
      logic [9:0]  idx;
      cmd_type     c;
      bit          found;
      target = items_sent + n_items;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 30 || (pick < 55 && write_starts.size() == 0)) begin
            case ($urandom_range(3))
               0: start = $urandom_range(SPRITE_START - 1, 0);
               1: start = $urandom_range(GRAPHICS_WORDS - 1, SPRITE_START);
               2: start = $urandom_range(GRAPHICS_WORDS - 1, GRAPHICS_WORDS - 8);
               default: start = $urandom_range(16'hffff);
            endcase
            len = (start >= SPRITE_START) ? $urandom_range(32, 1) : $urandom_range(8, 1);
            if (start < GRAPHICS_WORDS) begin
               write_starts.push_back(start);
               if (write_starts.size() > 64) void'(write_starts.pop_front());
            end
            send_item(CMD_SET_GADDR, 16'(start), 10'($urandom));
            for (k = 0; k < len; k++)
               send_item(CMD_WRITE_GRAM, 16'($urandom), 10'($urandom));
         end else if (pick < 55) begin
            if ($urandom_range(99) < 15)
               start = $urandom_range(16'hffff, GRAPHICS_WORDS);
            else
               start = write_starts[$urandom_range(write_starts.size() - 1)];
            send_item(CMD_SET_GADDR, 16'(start), 10'($urandom));
            len = $urandom_range(8, 1);
            for (k = 0; k < len; k++) begin
               // stop at the first word never written
               if (gram_addr < GRAPHICS_WORDS && !gram_written[gram_addr]) break;
               send_item(CMD_READ_GRAM, 16'($urandom), 10'($urandom));
            end
         end else if (pick < 70) begin
            case ($urandom_range(4))
               0, 1, 2: k = $urandom_range(REGISTER_COUNT - 1);
               3: k = $urandom_range(REGISTER_COUNT + 3, REGISTER_COUNT - 4);
               default: k = $urandom_range(127);
            endcase
            word = 16'($urandom);
            word[6:0] = 7'(k);
            send_item(CMD_SET_RADDR, word, 10'($urandom));
            len = $urandom_range(6, 1);
            for (k = 0; k < len; k++)
               send_item(CMD_WRITE_VREG, 16'($urandom), 10'($urandom));
         end else if (pick < 78) begin
            len = $urandom_range(6, 1);
            for (k = 0; k < len; k++) begin
               start = $urandom_range(SPRITE_WORDS - 1);
               found = 1'b0;
               idx = '0;
               for (j = 0; j < SPRITE_WORDS && !found; j++) begin
                  idx = 10'(start + j);
                  found = shown_known[idx];
               end
               if (found) send_item(CMD_READ_SPR, 16'($urandom), idx);
            end
         end else if (pick < 82) begin
            send_item(CMD_FRAME_END, 16'($urandom), 10'($urandom));
         end else if (pick < 88) begin
            send_item(CMD_NOP, 16'($urandom), 10'($urandom));
         end else begin
            c = cmd_type'($urandom_range(7));
            idx = 10'($urandom);
            if (!(c == CMD_READ_GRAM && gram_addr < GRAPHICS_WORDS && !gram_written[gram_addr])
                && !(c == CMD_READ_SPR && !shown_known[idx]))
               send_item(c, 16'($urandom), idx);
         end
      end
   endtask

   task automatic test_reset_state();
      send_item(CMD_READ_SPR, 16'($urandom), 10'd0);
      send_item(CMD_READ_SPR, 16'($urandom), 10'h3ff);
      drain_responses();
   endtask

   task automatic test_graphics_port();
      send_item(CMD_SET_GADDR, 16'h0000, 10'h3ff);
      send_item(CMD_WRITE_GRAM, 16'hffff, 10'h000);
      // last tile of the top layer, then the first sprite word
      send_item(CMD_SET_GADDR, 16'(SPRITE_START - 1), 10'h155);
      send_item(CMD_WRITE_GRAM, 16'ha5a5, 10'h2aa);
      send_item(CMD_WRITE_GRAM, 16'h1234, 10'h000);
      // last word in bound, then writes and reads past it
      send_item(CMD_SET_GADDR, 16'(GRAPHICS_WORDS - 1), 10'h3ff);
      send_item(CMD_WRITE_GRAM, 16'h5a5a, 10'h000);
      send_item(CMD_WRITE_GRAM, 16'h0f0f, 10'h000);
      send_item(CMD_READ_GRAM, 16'hffff, 10'h3ff);
      send_item(CMD_SET_GADDR, 16'h0000, 10'h000);
      send_item(CMD_READ_GRAM, 16'h0000, 10'h000);
      drain_responses();
   endtask

   task automatic test_register_file();
      // only the low seven bits of the address are kept
      send_item(CMD_SET_RADDR, 16'hff8f, 10'h000);
      send_item(CMD_WRITE_VREG, 16'h0080, 10'h3ff);
      send_item(CMD_SET_RADDR, 16'(REGISTER_COUNT - 1), 10'h000);
      send_item(CMD_WRITE_VREG, 16'hffff, 10'h000);
      send_item(CMD_WRITE_VREG, 16'h1111, 10'h000);
      send_item(CMD_SET_RADDR, 16'h000f, 10'h000);
      send_item(CMD_WRITE_VREG, 16'h0000, 10'h000);
      drain_responses();
   endtask

   task automatic test_frame_delay();
      send_item(CMD_FRAME_END, 16'h0000, 10'h000);
      send_item(CMD_READ_SPR, 16'h0000, 10'h000);
      send_item(CMD_FRAME_END, 16'hffff, 10'h3ff);
      send_item(CMD_READ_SPR, 16'hffff, 10'h000);
      send_item(CMD_READ_SPR, 16'h0000, 10'h3ff);
      send_item(CMD_NOP, 16'hffff, 10'h3ff);
      drain_responses();
   endtask

   task automatic test_random_traffic();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_traffic(200);
      drain_responses();
      send_idle_pct = 50;
      run_traffic(200);
      drain_responses();
      send_idle_pct = 0;
      rsp_stall_pct = 50;
      run_traffic(200);
      drain_responses();
      send_idle_pct = 24;
      rsp_stall_pct = 24;
      run_traffic(200);
      drain_responses();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      @(negedge clock);
      rsp_hold_cycles = 300;
      @(posedge clock);
      run_traffic(60);
      drain_responses();
   endtask

   task automatic clear_shadow_state();
      int i;
      for (i = 0; i < GRAPHICS_WORDS; i++) begin
         gram_words[i] = 16'h0;
         gram_written[i] = 1'b0;
      end
      for (i = 0; i < REGISTER_COUNT; i++) vregs[i] = 16'h0;
      for (i = 0; i < SPRITE_WORDS; i++) begin
         sprite_shown[i] = 16'h0;
         sprite_pending[i] = 16'h0;
         shown_known[i] = 1'b1;
         pending_known[i] = 1'b1;
      end
      gram_addr = 16'h0;
      vreg_addr = 7'h0;
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.cmd <= CMD_NOP;
      req_chan.data <= 16'h0;
      req_chan.sprite_index <= 10'h0;
      clear_shadow_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_graphics_port();
      test_register_file();
      test_frame_delay();
      test_random_traffic();
      test_backpressure();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
